FILE: rtl/core/rpq_pkg.sv
// Shared definitions for the render priority queue.
// Holds the stored entry layout, result status codes, request kinds and the priority and reset constants.
// No dependencies.
`default_nettype none

package rpq_pkg;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_LISTED   = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_ENTRY    = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // Request kinds.
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_FRAME   = 1'b1;

  // Texture number sits above this bit position in the priority.
  localparam int TEX_SHIFT = 24;

  // Reset value of the cleanup delay register.
  localparam logic [7:0] CLEANUP_DELAY_RST = 8'd8;

  // One stored entry of the sorted list.
  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] pri;
    logic               mark;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/rpq_mem.sv
// Entry memory of the render priority queue: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address.
// Depends on rpq_pkg for the entry layout.
`default_nettype none

module rpq_mem #(
  parameter int DEPTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire rpq_pkg::entry_t           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output rpq_pkg::entry_t                rdata
);

  rpq_pkg::entry_t mem [DEPTH];

  // Write and registered read; a read of the entry being written sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/render_priority_queue.sv
// Top level of the render priority queue; sequencer around the entry memory.
// Depends on rpq_pkg and rpq_mem.
//
// The block keeps up to DEPTH entries sorted by descending priority in one
// memory with a single read port, and each walk over that memory steps one
// entry per cycle unless the result side stalls it. An enabled enqueue beat
// first scans the list for a duplicate and the insert position; a duplicate
// gets its mark set and a full list answers full. Otherwise, when the new
// entry lands inside the list, each entry behind it is moved down; then the
// insert is written and the result is loaded. A frame beat emits one list
// entry per cycle while the result side takes them. When a prune is due, it
// then walks the list once more. Input beats are taken only while no
// operation is in progress. The memory needs no clearing pass after reset:
// only the first entry_count entries are ever read.
`default_nettype none

module render_priority_queue #(
  parameter int DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Configuration
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  // Request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_req_type,
  input  wire logic [15:0]        in_object_id,
  input  wire logic               in_draw_enable,
  input  wire logic [6:0]         in_texture_id,
  input  wire logic [31:0]        in_dist_sq_x100,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic [15:0]             out_entry_id,
  output logic signed [31:0]      out_entry_priority,
  output logic                    out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_INS   = 7'b0001000,
    S_RESP  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_PRUNE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic          found_r, found_nxt;
  logic          prune_r, prune_nxt;
  logic [7:0]    frame_r, frame_nxt;
  logic [7:0]    delay_r, delay_nxt;

  logic [15:0]        req_id_r, req_id_nxt;
  logic signed [31:0] req_pri_r, req_pri_nxt;
  logic [2:0]         res_status_r, res_status_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [15:0]        out_id_r, out_id_nxt;
  logic signed [31:0] out_pri_r, out_pri_nxt;
  logic               out_last_r, out_last_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  rpq_pkg::entry_t    mem_wdata;
  rpq_pkg::entry_t    mem_rdata;

  logic               out_free;
  logic signed [31:0] in_pri;
  logic [7:0]         frame_inc;
  logic               full;

  // Entry memory; the read address is always the next index, so the read
  // data in a cycle belongs to the entry at idx_r.
  rpq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_nxt[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Priority: texture above bit 24, minus the signed low half of the distance.
  assign in_pri = $signed({1'b0, in_texture_id, {rpq_pkg::TEX_SHIFT{1'b0}}})
                - $signed({{16{in_dist_sq_x100[15]}}, in_dist_sq_x100[15:0]});

  assign frame_inc = frame_r + 8'd1;
  assign full      = (count_r == CW'(DEPTH));
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    wr_nxt         = wr_r;
    found_nxt      = found_r;
    prune_nxt      = prune_r;
    frame_nxt      = frame_r;
    delay_nxt      = delay_r;
    req_id_nxt     = req_id_r;
    req_pri_nxt    = req_pri_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_pri_nxt    = out_pri_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = mem_rdata;

    if (cfg_we) begin
      delay_nxt = cfg_wdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_id_nxt  = in_object_id;
          req_pri_nxt = in_pri;
          idx_nxt     = '0;
          if (in_req_type == rpq_pkg::REQ_ENQUEUE) begin
            if (!in_draw_enable) begin
              res_status_nxt = rpq_pkg::ST_IGNORED;
              state_nxt      = S_RESP;
            end else begin
              found_nxt = 1'b0;
              pos_nxt   = count_r;
              state_nxt = S_SCAN;
            end
          end else begin
            // Frame bookkeeping is settled up front; the prune runs after emission.
            if (frame_inc >= delay_r) begin
              frame_nxt = 8'd0;
              prune_nxt = (count_r != '0);
            end else begin
              frame_nxt = frame_inc;
              prune_nxt = 1'b0;
            end
            if (count_r == '0) begin
              req_id_nxt     = 16'd0;
              req_pri_nxt    = 32'sd0;
              res_status_nxt = rpq_pkg::ST_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_EMIT;
            end
          end
        end
      end

      S_SCAN: begin
        if (idx_r == count_r) begin
          if (full) begin
            res_status_nxt = rpq_pkg::ST_FULL;
            state_nxt      = S_RESP;
          end else if (found_r) begin
            idx_nxt   = count_r - CW'(1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_INS;
          end
        end else if (mem_rdata.id == req_id_r) begin
          // Already listed: keep its place, set its mark.
          mem_we         = 1'b1;
          mem_waddr      = idx_r[AW-1:0];
          mem_wdata      = mem_rdata;
          mem_wdata.mark = 1'b1;
          res_status_nxt = rpq_pkg::ST_LISTED;
          state_nxt      = S_RESP;
        end else begin
          if (!found_r && (req_pri_r >= mem_rdata.pri)) begin
            found_nxt = 1'b1;
            pos_nxt   = idx_r;
          end
          idx_nxt = idx_r + CW'(1);
        end
      end

      S_SHIFT: begin
        // Move one entry down, walking from the tail toward the insert point.
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r + CW'(1));
        mem_wdata = mem_rdata;
        if (idx_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          idx_nxt = idx_r - CW'(1);
        end
      end

      S_INS: begin
        mem_we         = 1'b1;
        mem_waddr      = pos_r[AW-1:0];
        mem_wdata.id   = req_id_r;
        mem_wdata.pri  = req_pri_r;
        mem_wdata.mark = 1'b1;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = rpq_pkg::ST_INSERTED;
        state_nxt      = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = req_id_r;
          out_pri_nxt    = req_pri_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rpq_pkg::ST_ENTRY;
          out_id_nxt     = mem_rdata.id;
          out_pri_nxt    = mem_rdata.pri;
          out_last_nxt   = ((idx_r + CW'(1)) == count_r);
          if ((idx_r + CW'(1)) == count_r) begin
            if (prune_r) begin
              idx_nxt   = '0;
              wr_nxt    = '0;
              state_nxt = S_PRUNE;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end

      S_PRUNE: begin
        // Compact marked entries toward the head and clear their marks.
        if (idx_r == count_r) begin
          count_nxt = wr_r;
          state_nxt = S_IDLE;
        end else begin
          if (mem_rdata.mark) begin
            mem_we         = 1'b1;
            mem_waddr      = wr_r[AW-1:0];
            mem_wdata      = mem_rdata;
            mem_wdata.mark = 1'b0;
            wr_nxt         = wr_r + CW'(1);
          end
          idx_nxt = idx_r + CW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      frame_r     <= 8'd0;
      delay_r     <= rpq_pkg::CLEANUP_DELAY_RST;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      frame_r     <= frame_nxt;
      delay_r     <= delay_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    wr_r         <= wr_nxt;
    found_r      <= found_nxt;
    prune_r      <= prune_nxt;
    req_id_r     <= req_id_nxt;
    req_pri_r    <= req_pri_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_pri_r    <= out_pri_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_id       = out_id_r;
  assign out_entry_priority = out_pri_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/rpq_checker.sv
// Port-level checks for the render priority queue, bound to the top level.
// Depends on rpq_pkg for status codes and on render_priority_queue's ports.
`default_nettype none

module rpq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_entry_id,
  input wire logic [31:0] out_entry_priority,
  input wire logic        out_last
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_entry_id) && $stable(out_entry_priority) && $stable(out_last))
    else $error("stalled result beat changed");

  // Every enqueue answer is a single, final beat.
  a_enq_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == rpq_pkg::ST_INSERTED || out_status == rpq_pkg::ST_LISTED
      || out_status == rpq_pkg::ST_IGNORED || out_status == rpq_pkg::ST_FULL)
      |-> out_last)
    else $error("enqueue result without last");

  // An empty list answer carries zeros and ends the frame.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rpq_pkg::ST_EMPTY
      |-> out_last && out_entry_id == 16'd0 && out_entry_priority == 32'd0)
    else $error("empty list result malformed");

  // A result beat always carries one of the defined status codes.
  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= rpq_pkg::ST_EMPTY)
    else $error("result beat with an undefined status");

endmodule

bind render_priority_queue rpq_checker u_rpq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_entry_id       (out_entry_id),
  .out_entry_priority (out_entry_priority),
  .out_last           (out_last)
);

`default_nettype wire
